// ===== hdl/slea_pkg.sv =====
// Shared types and constants for the serial line echo assembler.
// Used by slea_ctrl, slea_dp and serial_line_echo_assembler_core.
`timescale 1ns / 1ps

package slea_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned FILL_W  = 6;
	localparam int unsigned PFX_LEN = 6;
	localparam int unsigned PFX_W   = 3;

	localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

	// Source of the byte loaded into the output register.
	typedef enum logic [2:0] {
		SEL_ECHO,
		SEL_PFX,
		SEL_CHAR,
		SEL_CR,
		SEL_LF
	} out_sel_t;

	typedef struct packed {
		logic             load;
		out_sel_t         sel;
		logic [PFX_W-1:0] pfx_idx;
		logic             last;
		logic             store_wr;
		logic             fill_clr;
		logic             idx_clr;
		logic             idx_inc;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_eol;
		logic fill_zero;
		logic fill_full;
		logic char_end;
	} sts_t;

	// Flush prefix: CR LF 'R' 'X' ':' space.
	function automatic logic [BYTE_W-1:0] pfx_byte(input logic [PFX_W-1:0] idx);
		logic [BYTE_W-1:0] b;
		unique case (idx)
			3'd0:    b = CH_CR;
			3'd1:    b = CH_LF;
			3'd2:    b = 8'h52;
			3'd3:    b = 8'h58;
			3'd4:    b = 8'h3A;
			3'd5:    b = 8'h20;
			default: b = 8'h20;
		endcase
		return b;
	endfunction

endpackage

// ===== hdl/slea_ctrl.sv =====
// Controller state machine of the serial line echo assembler.
// Depends on slea_pkg; drives the datapath slea_dp through cmd_t and reads sts_t.
`timescale 1ns / 1ps

module slea_ctrl import slea_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PFX,
		ST_CHARS,
		ST_CR,
		ST_LF
	} state_t;

	state_t           state_q, state_d;
	logic [PFX_W-1:0] pfx_cnt_q, pfx_cnt_d;

	always_comb begin
		state_d   = state_q;
		pfx_cnt_d = pfx_cnt_q;
		cmd       = '0;
		cmd.sel   = SEL_ECHO;
		cmd.pfx_idx = pfx_cnt_q;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = sts.out_free;
				if (s_tvalid && sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = SEL_ECHO;
					if (sts.is_eol && sts.fill_zero) begin
						state_d = ST_CR;
					end else if (!sts.is_eol && !sts.fill_full) begin
						cmd.store_wr = 1'b1;
						cmd.last     = 1'b1;
					end else begin
						// Line end with held characters, or a full line: flush it.
						cmd.idx_clr = 1'b1;
						pfx_cnt_d   = '0;
						state_d     = ST_PFX;
					end
				end
			end
			ST_PFX: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = SEL_PFX;
					if (pfx_cnt_q == PFX_W'(PFX_LEN - 1)) begin
						state_d = ST_CHARS;
					end else begin
						pfx_cnt_d = pfx_cnt_q + 1'b1;
					end
				end
			end
			ST_CHARS: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = SEL_CHAR;
					if (sts.char_end) begin
						state_d = ST_CR;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end
			end
			ST_CR: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					cmd.sel  = SEL_CR;
					state_d  = ST_LF;
				end
			end
			ST_LF: begin
				if (sts.out_free) begin
					cmd.load     = 1'b1;
					cmd.sel      = SEL_LF;
					cmd.last     = 1'b1;
					cmd.fill_clr = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pfx_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			pfx_cnt_q <= pfx_cnt_d;
		end
	end

	// Characters are only walked for a non-empty line.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PFX) |-> !sts.fill_zero)
		else $error("flush started on an empty line");

	// The prefix counter stays inside the prefix.
	assert property (@(posedge clk) disable iff (!arst_n)
		pfx_cnt_q <= PFX_W'(PFX_LEN - 1))
		else $error("prefix counter out of range");

	// A new item is taken only after the previous one closed its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !cmd.last) |=> (state_q != ST_IDLE))
		else $error("run left open after accepting an item");

endmodule

// ===== hdl/slea_dp.sv =====
// Datapath of the serial line echo assembler: line store, fill count,
// character index and output register. Depends on slea_pkg; driven by slea_ctrl.
`timescale 1ns / 1ps

module slea_dp import slea_pkg::*; #(
	parameter int unsigned LINE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] s_tdata,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  cmd_t              cmd,
	output sts_t              sts
);

	localparam int unsigned IDX_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [BYTE_W-1:0] line_mem [LINE_DEPTH];
	logic [BYTE_W-1:0] rd_data_q;
	logic [FILL_W-1:0] fill_q;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [BYTE_W-1:0] out_byte_q, out_byte_d;
	logic              out_last_q;
	logic              out_valid_q;

	assign sts.out_free  = !out_valid_q || m_tready;
	assign sts.is_eol    = (s_tdata == CH_CR) || (s_tdata == CH_LF);
	assign sts.fill_zero = (fill_q == '0);
	assign sts.fill_full = (fill_q == FILL_W'(LINE_DEPTH - 1));
	assign sts.char_end  = (FILL_W'(idx_q) == fill_q - 1'b1);

	always_comb begin
		if (cmd.idx_clr) begin
			idx_d = '0;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + 1'b1;
		end else begin
			idx_d = idx_q;
		end
	end

	// The store is read at the index of the next cycle, so rd_data_q
	// always holds the entry that idx_q points at.
	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			line_mem[fill_q[IDX_W-1:0]] <= s_tdata;
		end
		rd_data_q <= line_mem[idx_d];
	end

	always_comb begin
		unique case (cmd.sel)
			SEL_ECHO: out_byte_d = s_tdata;
			SEL_PFX:  out_byte_d = pfx_byte(cmd.pfx_idx);
			SEL_CHAR: out_byte_d = rd_data_q;
			SEL_CR:   out_byte_d = CH_CR;
			SEL_LF:   out_byte_d = CH_LF;
			default:  out_byte_d = s_tdata;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q <= out_byte_d;
			out_last_q <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.store_wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_last_q;
	assign m_tvalid = out_valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(LINE_DEPTH - 1))
		else $error("fill count beyond line capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |-> !sts.fill_full && !sts.is_eol)
		else $error("store write on a full line or a line end");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> sts.out_free)
		else $error("output register overwritten before its transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_clr |=> sts.fill_zero)
		else $error("line not emptied after flush");

endmodule

// ===== hdl/serial_line_echo_assembler_core.sv =====
// Channel  | Signals                      | Payload
// ---------+------------------------------+-------------------------------
// input    | s_tvalid s_tready s_tdata    | s_tdata[7:0] = rx_byte
// output   | m_tvalid m_tready m_tdata    | m_tdata[7:0] = tx_byte,
//          | m_tlast                      | m_tlast = run_last
//
// A stored character gives 1 transfer, an empty line end 3, and a flush
// 9 + held characters (40 at most for the default depth), paced by the
// controller emitting one byte per cycle while m_tready does not stall it.
// The line store is read one index ahead so characters leave back to back.
// arst_n clears the fill count, sequencer and output valid; the store is not cleared.
// A stall on m_tready holds the sequencer; the next input is taken once the run ends.
// Top level of the serial line echo assembler; depends on slea_pkg, slea_ctrl, slea_dp.
`timescale 1ns / 1ps

module serial_line_echo_assembler_core import slea_pkg::*; #(
	parameter int unsigned LINE_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,  // [7:0] rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,  // [7:0] tx_byte
	output logic              m_tlast
);

	cmd_t cmd;
	sts_t sts;

	slea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	slea_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
